// ===== hdl/dsa_pkg.sv =====
package dsa_pkg;

   localparam int VALUE_BITS = 31;
   localparam int SUM_BITS   = 34;
   // trial divisor never passes ceil(sqrt(2^VALUE_BITS)) + 1
   localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQ_BITS    = 2 * ROOT_BITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [ROOT_BITS-1:0]  root_type;
   typedef logic [SQ_BITS-1:0]    sq_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   localparam value_type LIMIT_RESET = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic      start;
      value_type dividend;
      root_type  divisor;
   } div_req_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      value_type quotient;
      logic      rem_zero;
   } div_rsp_type;

endpackage

// ===== hdl/dsa_if.sv =====
interface dsa_req_if;
   import dsa_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface dsa_rsp_if;
   import dsa_pkg::*;
   logic    valid;
   logic    ready;
   sum_type divisor_sum;
   logic    is_abundant;
   logic    is_amicable_lower;
   modport source (output valid, output divisor_sum, output is_abundant,
                   output is_amicable_lower, input ready);
   modport sink (input valid, input divisor_sum, input is_abundant,
                 input is_amicable_lower, output ready);
endinterface

interface dsa_csr_if;
   import dsa_pkg::*;
   logic      valid;
   logic      ready;
   value_type partner_limit;
   modport source (output valid, output partner_limit, input ready);
   modport sink (input valid, input partner_limit, output ready);
endinterface

// ===== hdl/dsa_div.sv =====
module dsa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dsa_pkg::div_req_type div_req,
   output dsa_pkg::div_rsp_type div_rsp
);
   import dsa_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   cnt_type              cnt_ff, cnt_in;
   value_type            quo_ff, quo_in;
   root_type             rem_ff, rem_in;
   root_type             dvs_ff, dvs_in;
   logic [ROOT_BITS:0]   rem_shift;
   logic [ROOT_BITS:0]   rem_diff;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? rem_diff[ROOT_BITS-1:0] : rem_shift[ROOT_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);

`ifndef SYNTH
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero count");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
`endif

endmodule

// ===== hdl/divisor_sum_amicable_abundant.sv =====
// channel   dir  handshake      payload
// req_chan  in   valid/ready    value[30:0]
// rsp_chan  out  valid/ready    divisor_sum[33:0], is_abundant, is_amicable_lower
// csr_chan  in   valid/ready    partner_limit[30:0] (ready always high)
//
// Each trial divisor d runs through the shared restoring divider (one
// quotient bit per cycle), first over value and then, when the partner sum
// is checked, over divisor_sum as well.
// Synchronous reset clears the sequencer and output valid; partner_limit resets to all ones.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a later result holds until that register frees up.
module divisor_sum_amicable_abundant (
   input logic        clock,
   input logic        reset,
   dsa_req_if.sink    req_chan,
   dsa_rsp_if.source  rsp_chan,
   dsa_csr_if.sink    csr_chan
);
   import dsa_pkg::*;

   localparam root_type D_FIRST   = ROOT_BITS'(2);
   localparam sq_type   SQ_FIRST  = SQ_BITS'(4);
   localparam sum_type  ACC_FIRST = SUM_BITS'(1);

   state_type   state_ff, state_in;
   logic        pass_ff, pass_in;
   value_type   n_ff, n_in;
   value_type   tgt_ff, tgt_in;
   root_type    d_ff, d_in;
   sq_type      sq_ff, sq_in;
   sum_type     acc_ff, acc_in;
   sum_type     sum_ff, sum_in;
   logic        abund_ff, abund_in;
   logic        amic_ff, amic_in;
   value_type   limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   sum_type     rsp_sum_ff, rsp_sum_in;
   logic        rsp_abund_ff, rsp_abund_in;
   logic        rsp_amic_ff, rsp_amic_in;

   logic        req_take;
   logic        out_free;
   logic        sq_lt;
   logic        sq_eq;
   sum_type     s_fin;
   logic        go_partner;
   div_req_type div_req;
   div_rsp_type div_rsp;

   dsa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign sq_lt          = sq_ff < SQ_BITS'(tgt_ff);
   assign sq_eq          = sq_ff == SQ_BITS'(tgt_ff);
   // root added once when the loop stops exactly on it
   assign s_fin          = acc_ff + (sq_eq ? SUM_BITS'(d_ff) : '0);
   assign go_partner     = (s_fin > SUM_BITS'(n_ff)) && (s_fin <= SUM_BITS'(limit_ff));

   assign div_req.start    = (state_ff == ST_TEST) && sq_lt;
   assign div_req.dividend = tgt_ff;
   assign div_req.divisor  = d_ff;

   assign csr_chan.ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_TEST;
         ST_TEST: state_in = sq_lt ? ST_DIV : ST_ROOT;
         ST_DIV:  if (div_rsp.done) state_in = ST_TEST;
         ST_ROOT: state_in = (!pass_ff && go_partner) ? ST_TEST : ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pass_in      = pass_ff;
      n_in         = n_ff;
      tgt_in       = tgt_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      abund_in     = abund_ff;
      amic_in      = amic_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_abund_in = rsp_abund_ff;
      rsp_amic_in  = rsp_amic_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pass_in = 1'b0;
               n_in    = req_chan.value;
               tgt_in  = req_chan.value;
               d_in    = D_FIRST;
               sq_in   = SQ_FIRST;
               acc_in  = ACC_FIRST;
            end
         end
         ST_TEST: begin
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  acc_in = acc_ff + SUM_BITS'(d_ff) + SUM_BITS'(div_rsp.quotient);
               end
               // (d+1)^2 = d^2 + 2d + 1
               sq_in = sq_ff + SQ_BITS'({d_ff, 1'b1});
               d_in  = d_ff + ROOT_BITS'(1);
            end
         end
         ST_ROOT: begin
            if (!pass_ff) begin
               sum_in   = s_fin;
               abund_in = s_fin > SUM_BITS'(n_ff);
               amic_in  = 1'b0;
               if (go_partner) begin
                  pass_in = 1'b1;
                  tgt_in  = s_fin[VALUE_BITS-1:0];
                  d_in    = D_FIRST;
                  sq_in   = SQ_FIRST;
                  acc_in  = ACC_FIRST;
               end
            end else begin
               amic_in = (s_fin == SUM_BITS'(n_ff));
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_ff;
               rsp_abund_in = abund_ff;
               rsp_amic_in  = amic_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            limit_ff <= csr_chan.partner_limit;
         end
      end
      n_ff         <= n_in;
      tgt_ff       <= tgt_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      abund_ff     <= abund_in;
      amic_ff      <= amic_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_abund_ff <= rsp_abund_in;
      rsp_amic_ff  <= rsp_amic_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.divisor_sum       = rsp_sum_ff;
   assign rsp_chan.is_abundant       = rsp_abund_ff;
   assign rsp_chan.is_amicable_lower = rsp_amic_ff;

`ifndef SYNTH
   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_rsp.busy || div_rsp.done)
      else $error("waiting on divider that is not running");
   a_partner_abundant: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) && pass_ff |-> sum_ff > SUM_BITS'(n_ff))
      else $error("partner pass on a sum that is not abundant");
   a_square_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |-> sq_ff == SQ_BITS'(d_ff) * SQ_BITS'(d_ff))
      else $error("running square lost track of divisor");
`endif

endmodule

// ===== tb/divisor_sum_amicable_abundant_tb.sv =====
`timescale 1ns / 1ps

module divisor_sum_amicable_abundant_tb;
   import dsa_pkg::*;

   localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;
   localparam value_type VALUE_MAX = '1;
   localparam int PAIR_COUNT = 10;

   typedef struct {
      value_type value;
      sum_type   divisor_sum;
      logic      is_abundant;
      logic      is_amicable_lower;
   } pending_type;

   typedef struct {
      value_type value;
      value_type limit;
      bit        typed;
      sum_type   divisor_sum;
      logic      is_abundant;
      logic      is_amicable_lower;
   } directed_row_type;

   // typed rows are the ones whose answer is obvious; the rest use the predictor
   directed_row_type directed_rows [21] = '{
      '{31'd1,       VALUE_MAX, 1'b1, 34'd1,    1'b0, 1'b0},
      '{31'd0,       VALUE_MAX, 1'b1, 34'd1,    1'b1, 1'b0},
      '{31'd2,       VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd3,       VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd4,       VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd6,       VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd12,      VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd25,      VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd28,      VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd220,     VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd284,     VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd945,     VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd1184,    VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0},
      '{VALUE_MAX,   VALUE_MAX, 1'b1, 34'd1,    1'b0, 1'b0},
      '{31'd220,     31'd284,   1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd220,     31'd283,   1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd12,      31'd283,   1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd220,     31'd1,     1'b0, 34'd0,    1'b0, 1'b0},
      '{31'd220,     31'd0,     1'b1, 34'd284,  1'b1, 1'b0},
      '{31'd1184,    31'd0,     1'b1, 34'd1210, 1'b1, 1'b0},
      '{31'd2620,    VALUE_MAX, 1'b0, 34'd0,    1'b0, 1'b0}
   };

   int unsigned pair_lower [PAIR_COUNT] = '{220, 1184, 2620, 5020, 6232,
                                            10744, 12285, 17296, 63020, 66928};
   int unsigned pair_upper [PAIR_COUNT] = '{284, 1210, 2924, 5564, 6368,
                                            10856, 14595, 18416, 76084, 66992};

   logic clock = 1'b0;
   logic reset;

   dsa_req_if req_if ();
   dsa_rsp_if rsp_if ();
   dsa_csr_if csr_if ();

   divisor_sum_amicable_abundant uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   pending_type     pending_results [$];
   pending_type     oldest;
   value_type       limit_copy;
   bit              steady = 1'b0;
   int unsigned     mismatch_count = 0;
   longint unsigned cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // trial division exactly as the block does it: sum starts at 1, root added once
   function automatic longint unsigned aliquot_sum(longint unsigned n);
      longint unsigned acc;
      longint unsigned d;
      acc = 1;
      d = 2;
      while (d * d < n) begin
         if (n % d == 0) begin
            acc += d + n / d;
         end
         d++;
      end
      if (d * d == n) begin
         acc += d;
      end
      return acc;
   endfunction

   function automatic pending_type classify_value(value_type v, value_type lim);
      pending_type e;
      longint unsigned s;
      s = aliquot_sum(v);
      e.value = v;
      e.divisor_sum = s[SUM_BITS-1:0];
      e.is_abundant = (s > v);
      e.is_amicable_lower = (s > v) && (s <= lim) && (aliquot_sum(s) == v);
      return e;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got,
                                  longint unsigned want, value_type v);
      $display("MISMATCH %s: got %0d expected %0d (value %0d) at cycle %0d",
               what, got, want, v, cycle_count);
      mismatch_count++;
   endtask

   task automatic send_value(pending_type e);
      if (!steady) begin
         while ($urandom_range(99) < 7) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.value <= e.value;
      do @(posedge clock); while (!req_if.ready);
      pending_results = {pending_results, e};
   endtask

   // limit only changes with the block idle
   task automatic write_limit(value_type lim);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.partner_limit <= lim;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      limit_copy = lim;
   endtask

   function automatic value_type pick_value();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(99);
      k = $urandom_range(PAIR_COUNT - 1);
      if (r < 55) return value_type'($urandom_range(3000, 1));
      if (r < 75) return value_type'($urandom_range(100000, 3001));
      if (r < 85) return value_type'(pair_lower[k]);
      if (r < 90) return value_type'(pair_upper[k]);
      return value_type'($urandom_range(64, 1));
   endfunction

   function automatic value_type pick_limit(int phase);
      int unsigned k;
      k = $urandom_range(PAIR_COUNT - 1);
      case (phase)
         0: return value_type'($urandom_range(32'h7fff_ffff, 1));
         1: return value_type'($urandom_range(20000, 200));
         2: return value_type'(pair_upper[k]);
         default: return VALUE_MAX;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_if.divisor_sum), '0, '0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_if.divisor_sum !== oldest.divisor_sum)
               report_mismatch("divisor_sum", 64'(rsp_if.divisor_sum),
                               64'(oldest.divisor_sum), oldest.value);
            if (rsp_if.is_abundant !== oldest.is_abundant)
               report_mismatch("is_abundant", 64'(rsp_if.is_abundant),
                               64'(oldest.is_abundant), oldest.value);
            if (rsp_if.is_amicable_lower !== oldest.is_amicable_lower)
               report_mismatch("is_amicable_lower", 64'(rsp_if.is_amicable_lower),
                               64'(oldest.is_amicable_lower), oldest.value);
         end
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 64'd1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      pending_type e;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      csr_if.valid = 1'b0;
      csr_if.partner_limit = '0;
      limit_copy = LIMIT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].limit != limit_copy) begin
            write_limit(directed_rows[i].limit);
         end
         if (directed_rows[i].typed) begin
            e.value = directed_rows[i].value;
            e.divisor_sum = directed_rows[i].divisor_sum;
            e.is_abundant = directed_rows[i].is_abundant;
            e.is_amicable_lower = directed_rows[i].is_amicable_lower;
         end else begin
            e = classify_value(directed_rows[i].value, limit_copy);
         end
         send_value(e);
      end

      // phase 2 runs with no idling on either side
      for (int phase = 0; phase < 4; phase++) begin
         write_limit(pick_limit(phase));
         steady = (phase == 2);
         for (int n = 0; n < 20; n++) begin
            send_value(classify_value(pick_value(), limit_copy));
         end
      end
      steady = 1'b0;
      req_if.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
